### hdl/assert_macros.svh
// Assertion macros shared by the encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define HTE_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("hub telemetry encoder assertion failed");

// The same, with a caller supplied message string.
`define HTE_ASSERT_MSG(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

`endif

### hdl/hte_pkg.sv
// Types and constants shared by the hub telemetry frame encoder modules.
package hte_pkg;

	localparam logic [7:0] FRAME_MARK  = 8'h5E;
	localparam logic [7:0] ESC_BYTE    = 8'h5D;
	localparam logic [7:0] ESC_OF_MARK = 8'h3E;
	localparam logic [7:0] ESC_OF_ESC  = 8'h3D;

	localparam logic REQ_DATA = 1'b0;
	localparam logic REQ_TAIL = 1'b1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One classified request, ready for the byte sequencer.
	typedef struct packed {
		logic       tail;
		logic [7:0] id;
		logic       lo_esc;
		logic [7:0] lo_first;
		logic [7:0] lo_second;
		logic       hi_esc;
		logic [7:0] hi_first;
		logic [7:0] hi_second;
	} desc_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic not_empty;
		logic full;
	} q_stat_t;

	typedef enum logic [2:0] {
		PH_HEAD,
		PH_ID,
		PH_LO,
		PH_LO_ESC,
		PH_HI,
		PH_HI_ESC
	} phase_t;

endpackage

### hdl/hub_telemetry_frame_encoder.sv
// A start beat is registered in the front end, then written into the queue, and its
// first byte is then registered onto strobe; busy, a full queue or an earlier frame can
// hold it between these steps. A data frame is four to six bytes (mark, id and each
// value byte, two when escaped); a tail request is the mark alone. The sequencer's one
// byte per cycle, while a request is queued, sets the rate; the receiver cannot stall.
// Reset (arst_n low) empties the input stage and the queue and drops strobe at once.
module hub_telemetry_frame_encoder import hte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [7:0]  data_id,
	input  logic [15:0] value,
	output logic        strobe,
	output logic [7:0]  out_byte,
	output logic        last
);

	// The front end registers each accepted beat and works out, for both
	// value bytes, whether they need escaping and what the escaped pair is.
	// It only raises busy when its register is full and the queue cannot
	// take the descriptor it holds.
	logic    push;
	desc_t   push_desc;
	logic    pop;
	desc_t   head;
	q_stat_t q_stat;

	hte_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req_type  (req_type),
		.data_id   (data_id),
		.value     (value),
		.q_stat    (q_stat),
		.push      (push),
		.push_desc (push_desc)
	);

	// A two entry queue decouples the front end from the sequencer, so a
	// new request can be taken while a long, escaped frame is still going out.
	hte_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	// The sequencer reads the queue head in place, sends one byte per cycle
	// while the queue is not empty and pops the descriptor on the final byte,
	// so back to back frames go out without a gap.
	hte_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.strobe   (strobe),
		.out_byte (out_byte),
		.last     (last)
	);

endmodule

### hdl/hte_front.sv
// Front end: accepts request beats and classifies them into descriptors.
module hte_front import hte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [7:0]  data_id,
	input  logic [15:0] value,
	input  q_stat_t     q_stat,
	output logic        push,
	output desc_t       push_desc
);

	logic       valid_s1;
	desc_t      desc_s1;
	desc_t      desc_d;
	logic       accept;
	logic [7:0] lo;
	logic [7:0] hi;

	assign busy   = valid_s1 && q_stat.full;
	assign accept = start && !busy;
	assign push   = valid_s1 && !q_stat.full;
	assign push_desc = desc_s1;

	assign lo = value[7:0];
	assign hi = value[15:8];

	// Each value byte is checked for the two reserved codes; the escaped
	// pair is worked out here so the back end only selects.
	always_comb begin
		desc_d.tail      = (req_type == REQ_TAIL);
		desc_d.id        = data_id;
		desc_d.lo_esc    = (lo == FRAME_MARK) || (lo == ESC_BYTE);
		desc_d.lo_first  = desc_d.lo_esc ? ESC_BYTE : lo;
		desc_d.lo_second = (lo == FRAME_MARK) ? ESC_OF_MARK : ESC_OF_ESC;
		desc_d.hi_esc    = (hi == FRAME_MARK) || (hi == ESC_BYTE);
		desc_d.hi_first  = desc_d.hi_esc ? ESC_BYTE : hi;
		desc_d.hi_second = (hi == FRAME_MARK) ? ESC_OF_MARK : ESC_OF_ESC;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= desc_d;
		end
	end

endmodule

### hdl/hte_queue.sv
// Short descriptor queue between the front end and the byte sequencer.
`include "assert_macros.svh"
module hte_queue import hte_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  desc_t   push_desc,
	input  logic    pop,
	output desc_t   head,
	output q_stat_t q_stat
);

	desc_t             mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign q_stat.not_empty = (count_q != '0);
	assign q_stat.full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign do_push = push && !q_stat.full;
	assign do_pop  = pop && q_stat.not_empty;
	assign head    = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_desc;
		end
	end

	`HTE_ASSERT_MSG(a_no_push_when_full, clk, arst_n, push |-> !q_stat.full, "push into full queue")
	`HTE_ASSERT_MSG(a_no_pop_when_empty, clk, arst_n, pop |-> q_stat.not_empty, "pop from empty queue")

endmodule

### hdl/hte_back.sv
// Back end: walks each descriptor out as a sequence of stuffed bytes.
`include "assert_macros.svh"
module hte_back import hte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  desc_t      head,
	input  q_stat_t    q_stat,
	output logic       pop,
	output logic       strobe,
	output logic [7:0] out_byte,
	output logic       last
);

	phase_t     phase_q;
	phase_t     phase_d;
	logic       emit;
	logic [7:0] byte_d;
	logic       last_d;
	logic       strobe_q;
	logic [7:0] out_byte_q;
	logic       last_q;

	assign emit = q_stat.not_empty;
	assign pop  = emit && last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		byte_d  = FRAME_MARK;
		last_d  = 1'b0;
		unique case (phase_q)
			PH_HEAD: begin
				byte_d  = FRAME_MARK;
				last_d  = head.tail;
				phase_d = head.tail ? PH_HEAD : PH_ID;
			end
			PH_ID: begin
				byte_d  = head.id;
				phase_d = PH_LO;
			end
			PH_LO: begin
				byte_d  = head.lo_first;
				phase_d = head.lo_esc ? PH_LO_ESC : PH_HI;
			end
			PH_LO_ESC: begin
				byte_d  = head.lo_second;
				phase_d = PH_HI;
			end
			PH_HI: begin
				byte_d  = head.hi_first;
				last_d  = !head.hi_esc;
				phase_d = head.hi_esc ? PH_HI_ESC : PH_HEAD;
			end
			PH_HI_ESC: begin
				byte_d  = head.hi_second;
				last_d  = 1'b1;
				phase_d = PH_HEAD;
			end
			default: begin
				phase_d = PH_HEAD;
			end
		endcase
		if (!emit) begin
			phase_d = phase_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= emit;
			last_q   <= emit && last_d;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= byte_d;
		end
	end

	assign strobe   = strobe_q;
	assign out_byte = out_byte_q;
	assign last     = last_q;

	// Once a frame has started, its bytes follow on consecutive cycles.
	`HTE_ASSERT(a_no_gap_in_frame, clk, arst_n, strobe_q && !last_q |=> strobe_q)
	// The beat after a final byte, if any, opens a new frame with the mark.
	`HTE_ASSERT(a_frame_opens_with_mark, clk, arst_n, strobe_q && last_q ##1 strobe_q |-> out_byte_q == FRAME_MARK)

endmodule
